// File: src/mandelbrot_escape_time_macros.svh
// assertion macros shared by the checker of the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define MANDEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mandel check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define MANDEL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mandel check failed");

`endif

// File: src/mandel_pkg.sv
// shared types, constants and helpers of the escape-time block
`timescale 1ns / 1ps
`default_nettype none
package mandel_pkg;

  // field widths
  localparam int PIX_W      = 11;
  localparam int Q_W        = 32;
  localparam int PAN_W      = 16;
  localparam int DIV_W      = 13;
  localparam int ITER_OUT_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIDE_W     = 64;

  // iteration limit and counter width
  localparam int MAX_ITERATIONS = 256;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

  // coordinate mapping: pixel plus pan, span, exact product, magnitude
  localparam int TERM_W  = 17;
  localparam int SPAN_W  = Q_W + 1;
  localparam int MPROD_W = TERM_W + SPAN_W;
  localparam int MAG_W   = MPROD_W - 1;
  localparam int CNT_W   = $clog2(MAG_W);

  // queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // 4.0 in Q8.24
  localparam logic signed [WIDE_W-1:0] ESCAPE_LIMIT = 64'sd67108864;

  // register reset values
  localparam logic signed [Q_W-1:0] VIEW_MIN_RST = -32'sd33554432;
  localparam logic signed [Q_W-1:0] VIEW_MAX_RST = 32'sd33554432;
  localparam logic [DIV_W-1:0]      SCALE_RST    = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_X_MIN    = 3'd0,
    CFG_VIEW_X_MAX    = 3'd1,
    CFG_VIEW_Y_MIN    = 3'd2,
    CFG_VIEW_Y_MAX    = 3'd3,
    CFG_PAN_X         = 3'd4,
    CFG_PAN_Y         = 3'd5,
    CFG_SCALE_DIVISOR = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ABS,
    F_DIV,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CROSS,
    B_RE,
    B_IM,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   view_x_min;
    logic signed [Q_W-1:0]   view_x_max;
    logic signed [Q_W-1:0]   view_y_min;
    logic signed [Q_W-1:0]   view_y_max;
    logic signed [PAN_W-1:0] pan_x;
    logic signed [PAN_W-1:0] pan_y;
    logic [DIV_W-1:0]        scale_divisor;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    logic signed [Q_W-1:0] c_re;
    logic signed [Q_W-1:0] c_im;
  } job_t;

  // sign extension of a Q8.24 word to the wide working width
  function automatic logic signed [WIDE_W-1:0] ext_q(input logic signed [Q_W-1:0] v);
    ext_q = {{(WIDE_W - Q_W){v[Q_W-1]}}, v};
  endfunction

  // clamp a wide signed value to the Q8.24 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    if (!v[WIDE_W-1] && (|v[WIDE_W-2:Q_W-1])) begin
      sat_q = {1'b0, {(Q_W - 1){1'b1}}};
    end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:Q_W-1])) begin
      sat_q = {1'b1, {(Q_W - 1){1'b0}}};
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/mandel_front.sv
// front end: takes a pixel beat and maps it to the complex point c
`timescale 1ns / 1ps
`default_nettype none
module mandel_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  mandel_pkg::cfg_t          cfg,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [mandel_pkg::PIX_W-1:0] in_pixel_x,
  input  wire [mandel_pkg::PIX_W-1:0] in_pixel_y,
  output logic                      job_valid,
  input  wire                       job_ready,
  output mandel_pkg::job_t          job
);
  import mandel_pkg::*;

  front_state_t state_r, state_nxt;

  logic [PIX_W-1:0]          px_r, py_r;
  logic                      axis_r;
  logic signed [MPROD_W-1:0] mprod_r;
  logic [MAG_W-1:0]          dvd_r;
  logic [DIV_W-1:0]          rem_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [Q_W-1:0]     c_re_r, c_im_r;

  logic signed [TERM_W-1:0]  term_w;
  logic signed [SPAN_W-1:0]  span_w;
  logic signed [MPROD_W-1:0] mprod_w;
  logic [MPROD_W-1:0]        mag_w;
  logic [DIV_W-1:0]          dsr_w;
  logic [DIV_W:0]            rem_sh_w;
  logic                      qbit_w;
  logic [DIV_W:0]            rem_nxt_w;
  logic signed [WIDE_W-1:0]  quo_w;
  logic signed [WIDE_W-1:0]  base_w;
  logic signed [WIDE_W-1:0]  sum_w;
  logic signed [Q_W-1:0]     coord_w;

  // axis select: x adds to view_x_min, y subtracts from view_y_max
  always_comb begin
    if (!axis_r) begin
      term_w = $signed({{(TERM_W - PIX_W){1'b0}}, px_r})
             + $signed({{(TERM_W - PAN_W){cfg.pan_x[PAN_W-1]}}, cfg.pan_x});
      span_w = $signed({cfg.view_x_max[Q_W-1], cfg.view_x_max})
             - $signed({cfg.view_x_min[Q_W-1], cfg.view_x_min});
      base_w = ext_q(cfg.view_x_min);
    end else begin
      term_w = $signed({{(TERM_W - PIX_W){1'b0}}, py_r})
             + $signed({{(TERM_W - PAN_W){cfg.pan_y[PAN_W-1]}}, cfg.pan_y});
      span_w = $signed({cfg.view_y_max[Q_W-1], cfg.view_y_max})
             - $signed({cfg.view_y_min[Q_W-1], cfg.view_y_min});
      base_w = ext_q(cfg.view_y_max);
    end
  end

  // exact offset times span
  assign mprod_w = term_w * span_w;
  assign mag_w   = mprod_r[MPROD_W-1] ? MPROD_W'(-mprod_r) : MPROD_W'(mprod_r);

  // restoring divide step, one quotient bit a cycle
  assign dsr_w     = (cfg.scale_divisor == '0) ? DIV_W'(1) : cfg.scale_divisor;
  assign rem_sh_w  = {rem_r, dvd_r[MAG_W-1]};
  assign qbit_w    = (rem_sh_w >= {1'b0, dsr_w});
  assign rem_nxt_w = qbit_w ? (rem_sh_w - {1'b0, dsr_w}) : rem_sh_w;

  // signed quotient, then offset from the window edge with clamping
  assign quo_w   = neg_r ? -$signed({{(WIDE_W - MAG_W){1'b0}}, dvd_r})
                         : $signed({{(WIDE_W - MAG_W){1'b0}}, dvd_r});
  assign sum_w   = axis_r ? (base_w - quo_w) : (base_w + quo_w);
  assign coord_w = sat_q(sum_w);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    job_valid = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = F_MUL;
      end
      F_MUL: state_nxt = F_ABS;
      F_ABS: state_nxt = F_DIV;
      F_DIV: begin
        if (cnt_r == CNT_W'(MAG_W - 1)) state_nxt = F_SUM;
      end
      F_SUM: state_nxt = axis_r ? F_PUSH : F_MUL;
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          px_r   <= in_pixel_x;
          py_r   <= in_pixel_y;
          axis_r <= 1'b0;
        end
      end
      F_MUL: mprod_r <= mprod_w;
      F_ABS: begin
        dvd_r <= mag_w[MAG_W-1:0];
        neg_r <= mprod_r[MPROD_W-1];
        rem_r <= '0;
        cnt_r <= '0;
      end
      F_DIV: begin
        dvd_r <= {dvd_r[MAG_W-2:0], qbit_w};
        rem_r <= rem_nxt_w[DIV_W-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
      F_SUM: begin
        if (!axis_r) begin
          c_re_r <= coord_w;
          axis_r <= 1'b1;
        end else begin
          c_im_r <= coord_w;
        end
      end
      default: ;
    endcase
  end

  // job beat towards the queue
  always_comb begin
    job.x    = px_r;
    job.y    = py_r;
    job.c_re = c_re_r;
    job.c_im = c_im_r;
  end

endmodule
`default_nettype wire

// File: src/mandel_queue.sv
// short queue of mapped jobs between front and back
`timescale 1ns / 1ps
`default_nettype none
module mandel_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  mandel_pkg::job_t push_job,
  output logic             pop_valid,
  input  wire              pop_ready,
  output mandel_pkg::job_t pop_job
);
  import mandel_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_Q-1:0] count_r;
  logic             push_w, pop_w;

  assign push_ready = (count_r != CNT_Q'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push_w     = push_valid && push_ready;
  assign pop_w      = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_w) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_w) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_w && !pop_w) begin
        count_r <= count_r + 1'b1;
      end else if (pop_w && !push_w) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // slot write
  always_ff @(posedge clk) begin
    if (push_w) slot_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

// File: src/mandel_back.sv
// back end: iterates z = z^2 + c on one shared multiplier and holds the result
`timescale 1ns / 1ps
`default_nettype none
module mandel_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              job_valid,
  output logic                             job_ready,
  input  mandel_pkg::job_t                 job,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mandel_pkg::PIX_W-1:0]     out_x,
  output logic [mandel_pkg::PIX_W-1:0]     out_y,
  output logic [mandel_pkg::ITER_OUT_W-1:0] out_iterations,
  output logic                             out_escaped
);
  import mandel_pkg::*;

  back_state_t state_r, state_nxt;

  job_t                     job_r;
  logic signed [Q_W-1:0]    z_re_r, z_im_r, re_sq_r;
  logic signed [WIDE_W-1:0] prod_r;
  logic [ITER_W-1:0]        iter_r;
  logic                     escaped_r;
  logic                     out_valid_r;
  logic [PIX_W-1:0]         out_x_r, out_y_r;
  logic [ITER_OUT_W-1:0]    out_iter_r;
  logic                     out_esc_r;

  logic signed [Q_W-1:0]    mul_a, mul_b;
  logic signed [WIDE_W-1:0] mul_p;
  logic signed [Q_W-1:0]    im_sq_w, re_sq_w, z_re_w, z_im_w;
  logic signed [WIDE_W-1:0] sq_sum_w;
  logic                     esc_w, stop_w, load_out;

  // shared multiplier, product registered every step
  assign mul_p = mul_a * mul_b;

  // im square comes straight off the product left by the last step
  assign im_sq_w  = sat_q(prod_r >>> 24);
  assign re_sq_w  = sat_q(prod_r >>> 24);
  assign sq_sum_w = ext_q(re_sq_r) + ext_q(im_sq_w);
  assign esc_w    = (sq_sum_w >= ESCAPE_LIMIT);
  assign stop_w   = esc_w || (iter_r == ITER_W'(MAX_ITERATIONS));

  // new z terms
  assign z_re_w = sat_q(ext_q(re_sq_r) - ext_q(im_sq_w) + ext_q(job_r.c_re));
  assign z_im_w = sat_q((prod_r >>> 23) - ext_q(job_r.c_im));

  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_ready);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, queue handshake and multiplier operands
  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    mul_a     = z_re_r;
    mul_b     = z_im_r;
    unique case (state_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_nxt = B_CROSS;
      end
      B_CROSS: state_nxt = stop_w ? B_DONE : B_RE;
      B_RE: begin
        mul_a     = z_re_r;
        mul_b     = z_re_r;
        state_nxt = B_IM;
      end
      B_IM: begin
        mul_a     = z_im_r;
        mul_b     = z_im_r;
        state_nxt = B_CROSS;
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // iteration datapath: cross term, re square, im square
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_r   <= job;
          z_re_r  <= '0;
          z_im_r  <= '0;
          re_sq_r <= '0;
          prod_r  <= '0;
          iter_r  <= '0;
        end
      end
      B_CROSS: begin
        if (stop_w) begin
          escaped_r <= esc_w;
        end else begin
          prod_r <= mul_p;
          z_re_r <= z_re_w;
        end
      end
      B_RE: begin
        z_im_r <= z_im_w;
        prod_r <= mul_p;
      end
      B_IM: begin
        re_sq_r <= re_sq_w;
        prod_r  <= mul_p;
        iter_r  <= iter_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= job_r.x;
      out_y_r    <= job_r.y;
      out_iter_r <= ITER_OUT_W'(iter_r);
      out_esc_r  <= escaped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_iterations = out_iter_r;
  assign out_escaped    = out_esc_r;

endmodule
`default_nettype wire

// File: src/mandelbrot_escape_time.sv
// Mandelbrot escape-time evaluator: one pixel beat in, one count beat out.
// Input channel in_valid/in_ready carries in_pixel_x and in_pixel_y.
// Output channel out_valid/out_ready carries out_x, out_y, out_iterations
// and out_escaped. Settings are written through cfg_we, cfg_index, cfg_data
// (index 0..6: view_x_min, view_x_max, view_y_min, view_y_max, pan_x, pan_y,
// scale_divisor); other indexes are dropped. Write them only while idle.
// The front maps a pixel to c with one multiply and a serial divider per
// axis, keeping in_ready low until the mapped job is pushed to the queue.
// The back runs each iteration as a cross-term, re-square and im-square step
// on one shared 32x32 multiplier.
// A two-entry queue lets the front map the next pixel while the back works.
// The front sets the pace of accepted pixels for short counts and the back
// loop for long ones.
// Reset is synchronous on rst_n: registers return to a -2..2 window with no
// pan and divisor 1024, the queue empties and no result is pending.
// When out_ready is low the result holds in the output register, the back
// waits, the queue fills and then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [mandel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mandel_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire [mandel_pkg::PIX_W-1:0]         in_pixel_x,
  input  wire [mandel_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mandel_pkg::PIX_W-1:0]        out_x,
  output logic [mandel_pkg::PIX_W-1:0]        out_y,
  output logic [mandel_pkg::ITER_OUT_W-1:0]   out_iterations,
  output logic                                out_escaped
);
  import mandel_pkg::*;

  cfg_t cfg_r;
  logic front_valid, front_ready;
  logic back_valid, back_ready;
  job_t front_job, back_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_x_min    <= VIEW_MIN_RST;
      cfg_r.view_x_max    <= VIEW_MAX_RST;
      cfg_r.view_y_min    <= VIEW_MIN_RST;
      cfg_r.view_y_max    <= VIEW_MAX_RST;
      cfg_r.pan_x         <= '0;
      cfg_r.pan_y         <= '0;
      cfg_r.scale_divisor <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VIEW_X_MIN:    cfg_r.view_x_min    <= cfg_data;
        CFG_VIEW_X_MAX:    cfg_r.view_x_max    <= cfg_data;
        CFG_VIEW_Y_MIN:    cfg_r.view_y_min    <= cfg_data;
        CFG_VIEW_Y_MAX:    cfg_r.view_y_max    <= cfg_data;
        CFG_PAN_X:         cfg_r.pan_x         <= cfg_data[PAN_W-1:0];
        CFG_PAN_Y:         cfg_r.pan_y         <= cfg_data[PAN_W-1:0];
        CFG_SCALE_DIVISOR: cfg_r.scale_divisor <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate mapping
  mandel_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .job_valid  (front_valid),
    .job_ready  (front_ready),
    .job        (front_job)
  );

  // decoupling queue
  mandel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  // escape-time iteration and result register
  mandel_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (back_valid),
    .job_ready      (back_ready),
    .job            (back_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_iterations (out_iterations),
    .out_escaped    (out_escaped)
  );

endmodule
`default_nettype wire

// File: src/mandel_checker.sv
// port-level checks of the escape-time block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_macros.svh"
module mandel_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [mandel_pkg::PIX_W-1:0]        out_x,
  input wire [mandel_pkg::PIX_W-1:0]        out_y,
  input wire [mandel_pkg::ITER_OUT_W-1:0]   out_iterations,
  input wire                                out_escaped
);
  import mandel_pkg::*;

  // a stalled result beat keeps its contents
  `MANDEL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_iterations) && $stable(out_escaped))

  // count never passes the limit
  `MANDEL_ASSERT_IMP(a_iter_bound, out_valid, out_iterations <= ITER_OUT_W'(MAX_ITERATIONS))

  // a point that stays bounded ran the full limit
  `MANDEL_ASSERT_IMP(a_bounded_full, out_valid && !out_escaped, out_iterations == ITER_OUT_W'(MAX_ITERATIONS))

  // escape needs at least one step, since z starts at zero
  `MANDEL_ASSERT_IMP(a_escape_step, out_valid && out_escaped, out_iterations != '0)

endmodule

bind mandelbrot_escape_time mandel_checker u_mandel_checker (.*);
`default_nettype wire
